/* src/mppg_pkg.sv */
// Shared constants and types of the multichannel phased PWM generator.
package mppg_pkg;

	// Default geometry.
	localparam int CHANNELS_DEF      = 16;
	localparam int COUNTER_STEPS_DEF = 4096;

	// Fixed field widths.
	localparam int ACTION_W   = 2;
	localparam int CHAN_W     = 4;
	localparam int COUNT_W    = 13;
	localparam int LEVELS_W   = 16;
	localparam int PRESCALE_W = 8;
	localparam int DISLVL_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Actions carried by an input word.
	localparam logic [ACTION_W-1:0] ACT_TICK      = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE     = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ      = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_WRITE_ALL = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DISLEVEL = 2'd2;

	// Disabled output levels.
	localparam logic [DISLVL_W-1:0] DIS_LOW  = 2'd0;
	localparam logic [DISLVL_W-1:0] DIS_HIGH = 2'd1;

	// Reset values and limits.
	localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 8'd30;
	localparam logic [PRESCALE_W-1:0] PRESCALE_FLOOR = 8'd3;
	localparam logic [COUNT_W-1:0]    RISE_RESET     = 13'd0;
	localparam logic [COUNT_W-1:0]    FALL_RESET     = 13'd4096;

	// One input word as held in the first stage.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAN_W-1:0]   channel;
		logic [COUNT_W-1:0]  on_count;
		logic [COUNT_W-1:0]  off_count;
		logic                output_enable;
	} item_t;

endpackage

/* src/mppg_level.sv */
// Level of one PWM channel from its rise and fall counts and the phase counter.
module mppg_level #(
	parameter int COUNTER_STEPS = mppg_pkg::COUNTER_STEPS_DEF,
	localparam int CNT_W = $clog2(COUNTER_STEPS)
) (
	input  logic [CNT_W-1:0]             phase,
	input  logic [mppg_pkg::COUNT_W-1:0] on_count,
	input  logic [mppg_pkg::COUNT_W-1:0] off_count,
	output logic                         level
);
	import mppg_pkg::*;

	// Compare width covers both the counts and the counter range.
	localparam int CMP_W = ((COUNT_W > CNT_W) ? COUNT_W : CNT_W) + 1;
	localparam logic [CMP_W-1:0] STEPS = CMP_W'(COUNTER_STEPS);

	logic [CMP_W-1:0] on_x;
	logic [CMP_W-1:0] off_x;
	logic [CMP_W-1:0] n_x;
	logic             full_on;
	logic             full_off;
	logic             in_window;

	assign on_x  = CMP_W'(on_count);
	assign off_x = CMP_W'(off_count);
	assign n_x   = CMP_W'(phase);

	assign full_on  = (on_x >= STEPS);
	assign full_off = (off_x >= STEPS);

	// Circular window from the rise count up to, but not including, the fall count.
	always_comb begin
		if (on_x < off_x) begin
			in_window = (n_x >= on_x) && (n_x < off_x);
		end else if (on_x > off_x) begin
			in_window = (n_x >= on_x) || (n_x < off_x);
		end else begin
			in_window = 1'b0;
		end
	end

	// Full on wins over full off.
	assign level = full_on || (!full_off && in_window);

endmodule

/* src/multichannel_phased_pwm_generator_unit.sv */
// Top level of the multichannel phased PWM generator.
//
// Port group   Handshake                  Contents
// item         item_valid / item_stall    action, channel, on_count, off_count, output_enable
// result       result_valid / result_stall pwm_levels, outputs_driven, read_on_count, read_off_count
// cfg          cfg_valid / cfg_ready      cfg_index, cfg_data (always ready)
//
// One word is accepted every clock unless item_stall is high; it passes the input
// register and then the result register, where it is held until it is taken.
// The rate is set by the two-stage pipeline: an input register, then the state
// update and all channel comparisons in parallel feeding the result register.
// Reset restores the configuration registers, the counter, the divider and both count tables.
// A stalled result holds the pipeline; a new word is still taken while only
// the result register is full.
module multichannel_phased_pwm_generator_unit #(
	parameter int CHANNELS      = mppg_pkg::CHANNELS_DEF,
	parameter int COUNTER_STEPS = mppg_pkg::COUNTER_STEPS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  logic [mppg_pkg::ACTION_W-1:0]   action,
	input  logic [mppg_pkg::CHAN_W-1:0]     channel,
	input  logic [mppg_pkg::COUNT_W-1:0]    on_count,
	input  logic [mppg_pkg::COUNT_W-1:0]    off_count,
	input  logic                            output_enable,
	output logic                            result_valid,
	input  logic                            result_stall,
	output logic [mppg_pkg::LEVELS_W-1:0]   pwm_levels,
	output logic                            outputs_driven,
	output logic [mppg_pkg::COUNT_W-1:0]    read_on_count,
	output logic [mppg_pkg::COUNT_W-1:0]    read_off_count,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mppg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mppg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mppg_pkg::*;

	localparam int CNT_W = $clog2(COUNTER_STEPS);
	localparam logic [CNT_W-1:0] PHASE_LAST = CNT_W'(COUNTER_STEPS - 1);

	// Configuration registers.
	logic [PRESCALE_W-1:0] prescale_q;
	logic                  invert_q;
	logic [DISLVL_W-1:0]   dislevel_q;

	// Block state.
	logic [CNT_W-1:0]      phase_q;
	logic [CNT_W-1:0]      phase_d;
	logic [PRESCALE_W-1:0] div_q;
	logic [PRESCALE_W-1:0] div_d;
	logic [PRESCALE_W-1:0] ps_eff;
	logic [COUNT_W-1:0]    rise_q [CHANNELS];
	logic [COUNT_W-1:0]    fall_q [CHANNELS];
	logic [COUNT_W-1:0]    rise_d [CHANNELS];
	logic [COUNT_W-1:0]    fall_d [CHANNELS];

	// Pipeline.
	logic                  valid_s1;
	item_t                 item_s1;
	logic                  result_take;
	logic                  item_fire;
	logic                  s1_fire;
	logic [CHANNELS-1:0]   lane_level;
	logic [LEVELS_W-1:0]   levels_raw;
	logic [LEVELS_W-1:0]   levels_out;
	logic                  driven_out;
	logic [COUNT_W-1:0]    rd_on;
	logic [COUNT_W-1:0]    rd_off;

	// Handshake.
	assign result_take = !result_valid || !result_stall;
	assign item_stall  = valid_s1 && !result_take;
	assign item_fire   = item_valid && !item_stall;
	assign s1_fire     = valid_s1 && result_take;
	assign cfg_ready   = 1'b1;

	// Configuration writes; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= PRESCALE_RESET;
			invert_q   <= 1'b0;
			dislevel_q <= DIS_LOW;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_PRESCALE: prescale_q <= cfg_data;
				REG_INVERT:   invert_q   <= cfg_data[0];
				REG_DISLEVEL: dislevel_q <= cfg_data[DISLVL_W-1:0];
				default:      ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_fire) begin
			item_s1.action        <= action;
			item_s1.channel       <= channel;
			item_s1.on_count      <= on_count;
			item_s1.off_count     <= off_count;
			item_s1.output_enable <= output_enable;
		end
	end

	// Divider and phase counter advance on a tick.
	assign ps_eff = (prescale_q < PRESCALE_FLOOR) ? PRESCALE_FLOOR : prescale_q;

	always_comb begin
		phase_d = phase_q;
		div_d   = div_q;
		if (item_s1.action == ACT_TICK) begin
			if (div_q >= ps_eff) begin
				div_d   = '0;
				phase_d = (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
			end else begin
				div_d = div_q + 1'b1;
			end
		end
	end

	// Count tables after the word: one channel or all channels written.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			rise_d[c] = rise_q[c];
			fall_d[c] = fall_q[c];
			if ((item_s1.action == ACT_WRITE_ALL) ||
			    ((item_s1.action == ACT_WRITE) && (int'(item_s1.channel) == c))) begin
				rise_d[c] = item_s1.on_count;
				fall_d[c] = item_s1.off_count;
			end
		end
	end

	// Read-back of one channel; zero when not a read or out of range.
	always_comb begin
		rd_on  = '0;
		rd_off = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			if ((item_s1.action == ACT_READ) && (int'(item_s1.channel) == c)) begin
				rd_on  = rise_q[c];
				rd_off = fall_q[c];
			end
		end
	end

	// State registers, updated as the word leaves the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			div_q   <= '0;
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c] <= RISE_RESET;
				fall_q[c] <= FALL_RESET;
			end
		end else if (s1_fire) begin
			phase_q <= phase_d;
			div_q   <= div_d;
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c] <= rise_d[c];
				fall_q[c] <= fall_d[c];
			end
		end
	end

	// One comparator per channel on the updated state.
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		mppg_level #(
			.COUNTER_STEPS(COUNTER_STEPS)
		) u_level (
			.phase    (phase_d),
			.on_count (rise_d[g]),
			.off_count(fall_d[g]),
			.level    (lane_level[g])
		);
	end

	// Only the first sixteen channels reach the output word.
	for (genvar b = 0; b < LEVELS_W; b++) begin : g_bit
		if (b < CHANNELS) begin : g_used
			assign levels_raw[b] = lane_level[b];
		end else begin : g_unused
			assign levels_raw[b] = 1'b0;
		end
	end

	// Inversion first, then the disabled level.
	always_comb begin
		levels_out = invert_q ? ~levels_raw : levels_raw;
		driven_out = 1'b1;
		if (!item_s1.output_enable) begin
			if (dislevel_q == DIS_LOW) begin
				levels_out = '0;
			end else if (dislevel_q == DIS_HIGH) begin
				levels_out = '1;
			end else begin
				levels_out = '0;
				driven_out = 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (result_take) begin
			result_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			pwm_levels     <= levels_out;
			outputs_driven <= driven_out;
			read_on_count  <= rd_on;
			read_off_count <= rd_off;
		end
	end

	// The phase counter stays within its range.
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(COUNTER_STEPS - 1) >= phase_q)
		else $error("phase counter out of range");

	// A divider that has reached the prescale restarts on the next tick.
	a_div_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.action == ACT_TICK && div_q >= ps_eff) |=> (div_q == '0))
		else $error("divider did not restart");

	// A word that is not a tick leaves the counter alone.
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && item_s1.action != ACT_TICK) |=> $stable(phase_q))
		else $error("phase counter moved without a tick");

	// High impedance outputs carry no levels.
	a_hiz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !outputs_driven) |-> (pwm_levels == '0))
		else $error("levels present while undriven");

	// The input side stalls only with a full first stage.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && result_valid && result_stall))
		else $error("input stalled without cause");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the multichannel phased PWM generator unit.
`timescale 1ns / 100ps

module testbench;
	import mppg_pkg::*;

	// Disabled levels that the package leaves unnamed; both give high impedance.
	localparam logic [DISLVL_W-1:0] DIS_HIGHZ  = 2'd2;
	localparam logic [DISLVL_W-1:0] DIS_SPARE  = 2'd3;
	localparam int                  STEPS      = COUNTER_STEPS_DEF;
	localparam int                  QUIET_MAX  = 2000;
	localparam int                  PHASES     = 6;
	localparam int                  PHASE_LEN  = 180;

	// Register settings for the random phases, phase 0 in the lowest slot.
	localparam logic [PHASES-1:0][PRESCALE_W-1:0] PHASE_PRESCALE =
		{8'd7, 8'd1, 8'd255, 8'd4, 8'd0, 8'd3};
	localparam logic [PHASES-1:0][DISLVL_W-1:0] PHASE_DISLVL =
		{DIS_LOW, DIS_HIGHZ, DIS_SPARE, DIS_HIGH, DIS_HIGHZ, DIS_LOW};

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [CHAN_W-1:0]   channel;
		logic [COUNT_W-1:0]  on_cnt;
		logic [COUNT_W-1:0]  off_cnt;
		logic                enable;
		int unsigned         gap;
	} pwm_word_t;

	typedef struct {
		logic [LEVELS_W-1:0] levels;
		logic                driven;
		logic [COUNT_W-1:0]  rd_on;
		logic [COUNT_W-1:0]  rd_off;
	} pwm_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_stall;
	logic [ACTION_W-1:0]   action = ACT_TICK;
	logic [CHAN_W-1:0]     channel = '0;
	logic [COUNT_W-1:0]    on_count = '0;
	logic [COUNT_W-1:0]    off_count = '0;
	logic                  output_enable = 1'b1;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [LEVELS_W-1:0]   pwm_levels;
	logic                  outputs_driven;
	logic [COUNT_W-1:0]    read_on_count;
	logic [COUNT_W-1:0]    read_off_count;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Words waiting to be sent and levels still owed by the block.
	pwm_word_t   pending_words[$];
	pwm_result_t owed_levels[$];
	pwm_word_t   held_word;
	bit          word_offered = 1'b0;
	bit          gap_armed = 1'b0;
	int unsigned gap_left = 0;
	bit          result_taken = 1'b0;
	int unsigned rx_wait = 0;
	int unsigned rx_hold_left = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	int          mismatches = 0;
	int          words_sent = 0;
	int          results_checked = 0;
	int          reg_writes = 0;
	int          quiet_cycles = 0;

	// Shadow of the block: configuration, counter, divider and count tables.
	logic [PRESCALE_W-1:0] shd_prescale;
	logic                  shd_invert;
	logic [DISLVL_W-1:0]   shd_dislvl;
	logic [11:0]           phase_count;
	logic [7:0]            tick_div;
	logic [COUNT_W-1:0]    rise_cnt [CHANNELS_DEF];
	logic [COUNT_W-1:0]    fall_cnt [CHANNELS_DEF];

	multichannel_phased_pwm_generator_unit uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.action         (action),
		.channel        (channel),
		.on_count       (on_count),
		.off_count      (off_count),
		.output_enable  (output_enable),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.pwm_levels     (pwm_levels),
		.outputs_driven (outputs_driven),
		.read_on_count  (read_on_count),
		.read_off_count (read_off_count),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Applies one word to the shadow state and returns the levels it should produce.
	function automatic pwm_result_t apply_pwm_word(input pwm_word_t w);
		pwm_result_t           r;
		logic [PRESCALE_W-1:0] ps;
		logic                  lvl;
		int                    on_c;
		int                    off_c;
		int                    n;
		r.levels = '0;
		r.driven = 1'b1;
		r.rd_on = '0;
		r.rd_off = '0;
		case (w.action)
			ACT_TICK: begin
				ps = (shd_prescale < PRESCALE_FLOOR) ? PRESCALE_FLOOR : shd_prescale;
				if (tick_div >= ps) begin
					tick_div = '0;
					phase_count = 12'((int'(phase_count) + 1) % STEPS);
				end else begin
					tick_div = tick_div + 8'd1;
				end
			end
			ACT_WRITE: begin
				rise_cnt[w.channel] = w.on_cnt;
				fall_cnt[w.channel] = w.off_cnt;
			end
			ACT_READ: begin
				r.rd_on = rise_cnt[w.channel];
				r.rd_off = fall_cnt[w.channel];
			end
			default: begin
				for (int c = 0; c < CHANNELS_DEF; c++) begin
					rise_cnt[c] = w.on_cnt;
					fall_cnt[c] = w.off_cnt;
				end
			end
		endcase
		// A channel is high inside the circular window [rise, fall).
		n = int'(phase_count);
		for (int c = 0; c < CHANNELS_DEF && c < LEVELS_W; c++) begin
			on_c = int'(rise_cnt[c]);
			off_c = int'(fall_cnt[c]);
			if (on_c >= STEPS)
				lvl = 1'b1;
			else if (off_c >= STEPS || on_c == off_c)
				lvl = 1'b0;
			else if (on_c < off_c)
				lvl = (n >= on_c) && (n < off_c);
			else
				lvl = (n >= on_c) || (n < off_c);
			r.levels[c] = lvl;
		end
		if (shd_invert)
			r.levels = ~r.levels;
		if (!w.enable) begin
			case (shd_dislvl)
				DIS_LOW:  r.levels = '0;
				DIS_HIGH: r.levels = '1;
				default: begin
					r.levels = '0;
					r.driven = 1'b0;
				end
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 40)
			$display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
	endtask

	// Sender: presents queued words after their drawn gap and holds each until taken.
	always @(negedge clk) begin
		if (arst_n && !word_offered && pending_words.size() > 0) begin
			if (!gap_armed) begin
				gap_left = pending_words[0].gap;
				gap_armed = 1'b1;
			end
			if (gap_left > 0) begin
				gap_left--;
			end else begin
				held_word = pending_words.pop_front();
				word_offered = 1'b1;
				gap_armed = 1'b0;
			end
		end
		item_valid <= word_offered;
		action <= held_word.action;
		channel <= held_word.channel;
		on_count <= held_word.on_cnt;
		off_count <= held_word.off_cnt;
		output_enable <= held_word.enable;
	end

	// Receiver: a long hold-off when asked, otherwise a drawn wait after each result.
	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken) begin
				result_taken = 1'b0;
				rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				result_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Monitor: checks each result against the oldest owed one, then predicts taken words.
	always @(posedge clk) begin: monitor
		pwm_result_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				result_taken = 1'b1;
				results_checked++;
				if (owed_levels.size() == 0) begin
					report_mismatch("result with no word outstanding", pwm_levels, 0);
				end else begin
					want = owed_levels.pop_front();
					if (pwm_levels !== want.levels)
						report_mismatch("pwm_levels", pwm_levels, want.levels);
					if (outputs_driven !== want.driven)
						report_mismatch("outputs_driven", outputs_driven, want.driven);
					if (read_on_count !== want.rd_on)
						report_mismatch("read_on_count", read_on_count, want.rd_on);
					if (read_off_count !== want.rd_off)
						report_mismatch("read_off_count", read_off_count, want.rd_off);
				end
			end
			if (item_valid && !item_stall) begin
				owed_levels.push_back(apply_pwm_word(held_word));
				word_offered = 1'b0;
				words_sent++;
			end
		end
	end

	// Watchdog: ends the run when nothing has moved on any channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_MAX) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [CHAN_W-1:0] ch,
			input logic [COUNT_W-1:0] on_c, input logic [COUNT_W-1:0] off_c,
			input logic en);
		pwm_word_t w;
		w.action = act;
		w.channel = ch;
		w.on_cnt = on_c;
		w.off_cnt = off_c;
		w.enable = en;
		w.gap = tx_calm ? 0 : $urandom_range(0, 14);
		pending_words.push_back(w);
	endtask

	// Counts cluster near the low end where the phase counter actually travels.
	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return COUNT_W'($urandom_range(0, 200));
			4:          return COUNT_W'(STEPS);
			5:          return $urandom_range(0, 1) ? COUNT_W'(STEPS - 1) : '0;
			6, 7:       return COUNT_W'($urandom_range(0, 8191));
			default:    return COUNT_W'($urandom_range(0, STEPS - 1));
		endcase
	endfunction

	task automatic queue_random_word();
		logic [ACTION_W-1:0] act;
		int unsigned         draw;
		draw = $urandom_range(0, 19);
		if (draw < 11)
			act = ACT_TICK;
		else if (draw < 15)
			act = ACT_WRITE;
		else if (draw < 19)
			act = ACT_READ;
		else
			act = ACT_WRITE_ALL;
		queue_word(act, CHAN_W'($urandom_range(0, 15)), pick_count(), pick_count(),
			$urandom_range(0, 7) != 0);
	endtask

	task automatic wait_for_drain();
		do
			@(negedge clk);
		while (pending_words.size() != 0 || word_offered || owed_levels.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_PRESCALE: shd_prescale = val;
			REG_INVERT:   shd_invert = val[0];
			REG_DISLEVEL: shd_dislvl = val[DISLVL_W-1:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin: stimulus
		held_word = '{ACT_TICK, '0, '0, '0, 1'b1, 0};
		shd_prescale = PRESCALE_RESET;
		shd_invert = 1'b0;
		shd_dislvl = DIS_LOW;
		phase_count = '0;
		tick_div = '0;
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			rise_cnt[c] = RISE_RESET;
			fall_cnt[c] = FALL_RESET;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset contents, count extremes, equal counts, wrapped windows and above-full values.
		queue_word(ACT_READ, 4'd0, '0, '0, 1'b1);
		queue_word(ACT_READ, 4'd15, '0, '0, 1'b1);
		queue_word(ACT_WRITE, 4'd0, 13'd0, 13'd4095, 1'b1);
		queue_word(ACT_WRITE, 4'd15, 13'd4096, 13'd4096, 1'b1);
		queue_word(ACT_WRITE, 4'd1, 13'd8191, 13'd0, 1'b1);
		queue_word(ACT_WRITE, 4'd2, 13'd5, 13'd5, 1'b1);
		queue_word(ACT_WRITE, 4'd3, 13'd100, 13'd8191, 1'b1);
		queue_word(ACT_WRITE, 4'd4, 13'd4095, 13'd0, 1'b1);
		queue_word(ACT_WRITE, 4'd5, 13'd4000, 13'd10, 1'b1);
		queue_word(ACT_WRITE, 4'd6, 13'd1, 13'd3, 1'b1);
		queue_word(ACT_READ, 4'd1, '0, '0, 1'b1);
		queue_word(ACT_READ, 4'd3, 13'h1fff, 13'h1fff, 1'b1);
		repeat (5) queue_word(ACT_TICK, 4'd0, '0, '0, 1'b1);
		queue_word(ACT_TICK, 4'd0, '0, '0, 1'b0);
		wait_for_drain();

		// Prescale lowered below the divider, so the next tick must advance the counter.
		write_register(REG_PRESCALE, 8'd3);
		write_register(REG_INVERT, 8'd1);
		write_register(REG_DISLEVEL, 8'(DIS_HIGH));
		repeat (6) queue_word(ACT_TICK, 4'd0, '0, '0, 1'b1);
		queue_word(ACT_TICK, 4'd0, '0, '0, 1'b0);
		queue_word(ACT_READ, 4'd6, '0, '0, 1'b0);
		wait_for_drain();
		write_register(REG_DISLEVEL, 8'(DIS_HIGHZ));
		queue_word(ACT_TICK, 4'd0, '0, '0, 1'b0);
		queue_word(ACT_READ, 4'd2, '0, '0, 1'b1);
		wait_for_drain();
		write_register(REG_DISLEVEL, 8'(DIS_SPARE));
		queue_word(ACT_TICK, 4'd0, '0, '0, 1'b0);
		wait_for_drain();
		write_register(REG_INVERT, 8'd0);
		queue_word(ACT_WRITE_ALL, 4'd0, 13'd0, 13'd4096, 1'b1);
		queue_word(ACT_WRITE_ALL, 4'd0, 13'd4096, 13'd0, 1'b1);
		queue_word(ACT_READ, 4'd9, '0, '0, 1'b1);

		// Random phases, each under its own register setting and idling pattern.
		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			write_register(REG_PRESCALE, PHASE_PRESCALE[p]);
			write_register(REG_INVERT, 8'(p % 2));
			write_register(REG_DISLEVEL, 8'(PHASE_DISLVL[p]));
			@(posedge clk);
			tx_calm = (p == 0 || p == 4);
			rx_calm = (p == 0 || p == 3);
			if (p == 2) begin
				// Receiver holds off while words keep coming, so the pipeline backs up.
				rx_hold_left = 120;
				tx_calm = 1'b1;
				repeat (40) queue_random_word();
				tx_calm = 1'b0;
			end
			repeat (PHASE_LEN) queue_random_word();
		end

		wait_for_drain();
		repeat (10) @(posedge clk);
		if (owed_levels.size() != 0)
			report_mismatch("results never delivered", 0, owed_levels.size());
		$display("tb: %0d words driven, %0d results checked, %0d register writes",
			words_sent, results_checked, reg_writes);
		$display("tb: all four actions, both inversions and all disabled levels; counter at %0d",
			phase_count);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
